// ----- src/bqc_pkg.sv -----
package bqc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int EXP_BITS = 20;
  localparam int XYW = 34;

  typedef logic signed [XYW-1:0] xy_t;

  typedef enum logic {
    REG_SAMPLE_RATE = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_HIGHPASS,
    KIND_LOWPASS,
    KIND_PEAK
  } band_kind_t;

  localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;
  localparam logic [15:0] Q_MIN = 16'd410;
  localparam logic [15:0] Q_MAX = 16'd40960;
  localparam logic signed [13:0] GAIN_MIN = -14'sd4608;
  localparam logic signed [13:0] GAIN_MAX = 14'sd4608;
  localparam logic signed [33:0] GAIN_LOG2 = 34'sd348329;
  localparam logic [30:0] PHASE_SCALE = 31'd1686629713;
  localparam logic [30:0] PHASE_SAT = 31'h7fffffff;
  localparam logic [30:0] QUARTER_TURN = 31'h40000000;
  localparam logic [31:0] HALF_TURN = 32'h80000000;
  localparam logic [30:0] EXP_ONE = 31'h40000000;
  localparam xy_t CORDIC_X0 = 34'sd652032874;
  localparam logic signed [37:0] ONE_Q30 = 38'sd1073741824;
  localparam logic [31:0] COEF_POS_MAX = 32'h7fffffff;
  localparam logic [31:0] COEF_NEG_MAX = 32'h80000000;

  typedef struct packed {
    logic [2:0] stage;
    logic [18:0] f16;
    logic [15:0] q;
    logic limited;
    logic signed [2:0] n;
  } exp_pay_t;

  typedef struct packed {
    logic [2:0] stage;
    logic [15:0] q;
    logic limited;
    logic [31:0] amp;
    logic [31:0] inv;
  } ph_pay_t;

  typedef struct packed {
    logic [2:0] stage;
    logic [15:0] q;
    logic limited;
    logic [31:0] amp;
    logic [31:0] inv;
    logic negcos;
  } cor_pay_t;

  typedef struct packed {
    logic [2:0] stage;
    logic limited;
    logic [31:0] amp;
    logic [31:0] inv;
    xy_t cc;
  } al_pay_t;

  typedef struct packed {
    logic [2:0] stage;
    logic limited;
    logic neg;
    logic ovf;
  } qd_pay_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd843314856;
      1: v = 32'd497837829;
      2: v = 32'd263043836;
      3: v = 32'd133525158;
      4: v = 32'd67021686;
      5: v = 32'd33543515;
      6: v = 32'd16775850;
      7: v = 32'd8388437;
      8: v = 32'd4194282;
      9: v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 2^(2^-k) in q30
  function automatic logic [30:0] root2_q30(input int k);
    logic [30:0] v;
    case (k)
      1: v = 31'd1518500250;
      2: v = 31'd1276901417;
      3: v = 31'd1170923762;
      4: v = 31'd1121280436;
      5: v = 31'd1097253708;
      6: v = 31'd1085434106;
      7: v = 31'd1079572136;
      8: v = 31'd1076653034;
      9: v = 31'd1075196444;
      10: v = 31'd1074468888;
      11: v = 31'd1074105294;
      12: v = 31'd1073923544;
      13: v = 31'd1073832680;
      14: v = 31'd1073787251;
      15: v = 31'd1073764537;
      16: v = 31'd1073753181;
      17: v = 31'd1073747502;
      18: v = 31'd1073744663;
      19: v = 31'd1073743244;
      20: v = 31'd1073742534;
      default: v = EXP_ONE;
    endcase
    return v;
  endfunction

endpackage

// ----- src/bqc_div_cell.sv -----
module bqc_div_cell #(
  parameter int DENW = 18,
  parameter int NW = 31,
  parameter int QW = 31,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DENW-1:0] in_rem,
  input  logic [DENW-1:0] in_den,
  input  logic [NW-1:0]   in_num,
  input  logic [QW-1:0]   in_quo,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [DENW-1:0] out_rem,
  output logic [DENW-1:0] out_den,
  output logic [NW-1:0]   out_num,
  output logic [QW-1:0]   out_quo,
  output logic [PW-1:0]   out_pay
);

  logic [DENW:0] trial;
  logic [DENW:0] diff;
  logic          fits;

  assign trial = {in_rem, in_num[NW-1]};
  assign diff = trial - {1'b0, in_den};
  assign fits = trial >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= fits ? diff[DENW-1:0] : trial[DENW-1:0];
      out_den <= in_den;
      out_num <= {in_num[NW-2:0], 1'b0};
      out_quo <= {in_quo[QW-2:0], fits};
      out_pay <= in_pay;
    end
  end

endmodule

// ----- src/bqc_exp_cell.sv -----
module bqc_exp_cell #(
  parameter int K = 1,
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [30:0]                   in_r,
  input  logic [bqc_pkg::EXP_BITS-1:0]  in_frac,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_valid,
  output logic [30:0]                   out_r,
  output logic [bqc_pkg::EXP_BITS-1:0]  out_frac,
  output logic [PW-1:0]                 out_pay
);

  localparam logic [30:0] ROOT = bqc_pkg::root2_q30(K);

  logic [61:0] prod;

  assign prod = 62'(in_r) * 62'(ROOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= in_frac[bqc_pkg::EXP_BITS-1] ? prod[60:30] : in_r;
      out_frac <= {in_frac[bqc_pkg::EXP_BITS-2:0], 1'b0};
      out_pay <= in_pay;
    end
  end

endmodule

// ----- src/bqc_cordic_cell.sv -----
module bqc_cordic_cell #(
  parameter int I = 0,
  parameter int PW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  bqc_pkg::xy_t        in_x,
  input  bqc_pkg::xy_t        in_y,
  input  bqc_pkg::xy_t        in_z,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output bqc_pkg::xy_t        out_x,
  output bqc_pkg::xy_t        out_y,
  output bqc_pkg::xy_t        out_z,
  output logic [PW-1:0]       out_pay
);

  localparam bqc_pkg::xy_t ANG = bqc_pkg::xy_t'(bqc_pkg::atan_q30(I));

  bqc_pkg::xy_t dx;
  bqc_pkg::xy_t dy;

  assign dx = in_y >>> I;
  assign dy = in_x >>> I;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!in_z[bqc_pkg::XYW-1]) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ANG;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ANG;
      end
      out_pay <= in_pay;
    end
  end

endmodule

// ----- src/biquad_eq_coefficient_calc_unit.sv -----
// Biquad equalizer coefficient unit: each s_ beat is one band request, each m_ beat
// the five normalized coefficients (signed Q3.28) of that band, in request order.
// One request enters per clock and results leave one per clock unless the output
// stalls; each passes the cell chain of 20 exp2 cells, 31 phase divider cells,
// 24 CORDIC cells, 34 alpha divider cells, 32 cells in each of the five
// coefficient dividers, and 7 plain stages around them. The whole chain holds while
// an output beat waits on m_tready. The sample rate register sits at address 0; the
// user must write it only while no request is in flight; the block does not check.
module biquad_eq_coefficient_calc_unit #(
  parameter int NUM_STAGES = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // centre_freq [18:0], quality [34:19], gain_db [48:35]
  input  logic [55:0]  s_tdata,
  // stage_index [2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // coef_b0 [31:0], coef_b1 [63:32], coef_b2 [95:64], coef_a1 [127:96], coef_a2 [159:128]
  output logic [159:0] m_tdata,
  // stage_out [2:0], freq_limited [3]
  output logic [3:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int EXPN = bqc_pkg::EXP_BITS;
  localparam int CORN = bqc_pkg::CORDIC_STEPS;
  localparam int PH_STEPS = 31;
  localparam int AL_STEPS = 34;
  localparam int QD_STEPS = 32;
  localparam int QD_DENW = 37;
  localparam int LANES = 5;
  localparam int EXP_PW = $bits(bqc_pkg::exp_pay_t);
  localparam int PH_PW = $bits(bqc_pkg::ph_pay_t);
  localparam int COR_PW = $bits(bqc_pkg::cor_pay_t);
  localparam int AL_PW = $bits(bqc_pkg::al_pay_t);
  localparam int QD_PW = $bits(bqc_pkg::qd_pay_t);

  function automatic logic [31:0] exp_shift(input logic [30:0] r, input logic signed [2:0] n);
    logic [31:0] v;
    v = 32'(r);
    if (!n[2]) begin
      return v << n[0];
    end
    return v >> (-n);
  endfunction

  // config register
  logic [17:0] fs_hz;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_hz <= bqc_pkg::SAMPLE_RATE_RESET;
    end else if (psel && penable && pwrite &&
                 bqc_pkg::reg_idx_t'(paddr[2]) == bqc_pkg::REG_SAMPLE_RATE) begin
      fs_hz <= pwdata[17:0];
    end
  end

  always_comb begin
    if (bqc_pkg::reg_idx_t'(paddr[2]) == bqc_pkg::REG_SAMPLE_RATE) begin
      prdata = 32'(fs_hz);
    end else begin
      prdata = '0;
    end
  end

  logic en;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage
  logic [18:0]        in_f16;
  logic [15:0]        in_q;
  logic signed [13:0] in_g;
  logic [15:0]        q_cl;
  logic signed [13:0] g_cl;

  assign in_f16 = s_tdata[18:0];
  assign in_q = s_tdata[34:19];
  assign in_g = s_tdata[48:35];

  always_comb begin
    if (in_q < bqc_pkg::Q_MIN) begin
      q_cl = bqc_pkg::Q_MIN;
    end else if (in_q > bqc_pkg::Q_MAX) begin
      q_cl = bqc_pkg::Q_MAX;
    end else begin
      q_cl = in_q;
    end
    if (in_g < bqc_pkg::GAIN_MIN) begin
      g_cl = bqc_pkg::GAIN_MIN;
    end else if (in_g > bqc_pkg::GAIN_MAX) begin
      g_cl = bqc_pkg::GAIN_MAX;
    end else begin
      g_cl = in_g;
    end
  end

  logic               ia_valid;
  logic [2:0]         ia_stage;
  logic [18:0]        ia_f16;
  logic [15:0]        ia_q;
  logic signed [13:0] ia_g;
  logic               ia_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      ia_valid <= 1'b0;
    end else if (en) begin
      ia_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia_stage <= s_tuser;
      ia_f16 <= in_f16;
      ia_q <= q_cl;
      ia_g <= g_cl;
      ia_lim <= {2'b00, in_f16} >= {fs_hz, 3'b000};
    end
  end

  // exp2 chains for A and 1/A
  logic signed [33:0] e_pos;
  logic signed [33:0] e_neg;

  assign e_pos = 34'(ia_g) * bqc_pkg::GAIN_LOG2;
  assign e_neg = -e_pos;

  logic                  ex_valid [EXPN+1];
  logic [30:0]           ex_r     [EXPN+1];
  logic [EXPN-1:0]       ex_frac  [EXPN+1];
  bqc_pkg::exp_pay_t     ex_pay   [EXPN+1];
  logic                  iv_valid [EXPN+1];
  logic [30:0]           iv_r     [EXPN+1];
  logic [EXPN-1:0]       iv_frac  [EXPN+1];
  logic [2:0]            iv_n     [EXPN+1];

  assign ex_valid[0] = ia_valid;
  assign ex_r[0] = bqc_pkg::EXP_ONE;
  assign ex_frac[0] = e_pos[29:30-EXPN];
  assign ex_pay[0] = '{stage: ia_stage, f16: ia_f16, q: ia_q, limited: ia_lim,
                       n: e_pos[32:30]};
  assign iv_valid[0] = ia_valid;
  assign iv_r[0] = bqc_pkg::EXP_ONE;
  assign iv_frac[0] = e_neg[29:30-EXPN];
  assign iv_n[0] = e_neg[32:30];

  for (genvar k = 0; k < EXPN; k++) begin : g_exp
    bqc_exp_cell #(.K(k + 1), .PW(EXP_PW)) u_amp (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(ex_valid[k]), .in_r(ex_r[k]), .in_frac(ex_frac[k]), .in_pay(ex_pay[k]),
      .out_valid(ex_valid[k+1]), .out_r(ex_r[k+1]), .out_frac(ex_frac[k+1]),
      .out_pay(ex_pay[k+1])
    );
    bqc_exp_cell #(.K(k + 1), .PW(3)) u_inv (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(iv_valid[k]), .in_r(iv_r[k]), .in_frac(iv_frac[k]), .in_pay(iv_n[k]),
      .out_valid(iv_valid[k+1]), .out_r(iv_r[k+1]), .out_frac(iv_frac[k+1]),
      .out_pay(iv_n[k+1])
    );
  end

  // phase divider: f16 * 2^28 / fs_hz
  logic              ph_valid [PH_STEPS+1];
  logic [17:0]       ph_rem   [PH_STEPS+1];
  logic [17:0]       ph_den   [PH_STEPS+1];
  logic [30:0]       ph_num   [PH_STEPS+1];
  logic [30:0]       ph_quo   [PH_STEPS+1];
  bqc_pkg::ph_pay_t  ph_pay   [PH_STEPS+1];

  assign ph_valid[0] = ex_valid[EXPN] & iv_valid[EXPN];
  assign ph_rem[0] = 18'(ex_pay[EXPN].f16[18:3]);
  assign ph_den[0] = fs_hz;
  assign ph_num[0] = {ex_pay[EXPN].f16[2:0], 28'd0};
  assign ph_quo[0] = '0;
  assign ph_pay[0] = '{stage: ex_pay[EXPN].stage, q: ex_pay[EXPN].q,
                       limited: ex_pay[EXPN].limited,
                       amp: exp_shift(ex_r[EXPN], ex_pay[EXPN].n),
                       inv: exp_shift(iv_r[EXPN], iv_n[EXPN])};

  for (genvar k = 0; k < PH_STEPS; k++) begin : g_ph
    bqc_div_cell #(.DENW(18), .NW(PH_STEPS), .QW(PH_STEPS), .PW(PH_PW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(ph_valid[k]), .in_rem(ph_rem[k]), .in_den(ph_den[k]),
      .in_num(ph_num[k]), .in_quo(ph_quo[k]), .in_pay(ph_pay[k]),
      .out_valid(ph_valid[k+1]), .out_rem(ph_rem[k+1]), .out_den(ph_den[k+1]),
      .out_num(ph_num[k+1]), .out_quo(ph_quo[k+1]), .out_pay(ph_pay[k+1])
    );
  end

  // fold into the first quadrant
  logic [30:0]      t_raw;
  logic             fd_valid;
  logic [30:0]      fd_t;
  logic             fd_neg;
  bqc_pkg::ph_pay_t fd_pay;

  assign t_raw = ph_pay[PH_STEPS].limited ? bqc_pkg::PHASE_SAT : ph_quo[PH_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      fd_valid <= 1'b0;
    end else if (en) begin
      fd_valid <= ph_valid[PH_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (t_raw > bqc_pkg::QUARTER_TURN) begin
        fd_t <= 31'(bqc_pkg::HALF_TURN - 32'(t_raw));
        fd_neg <= 1'b1;
      end else begin
        fd_t <= t_raw;
        fd_neg <= 1'b0;
      end
      fd_pay <= ph_pay[PH_STEPS];
    end
  end

  // angle in radians, q30
  logic [61:0]      z_prod;
  logic             mz_valid;
  bqc_pkg::xy_t     mz_z;
  logic             mz_neg;
  bqc_pkg::ph_pay_t mz_pay;

  assign z_prod = 62'(fd_t) * 62'(bqc_pkg::PHASE_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mz_valid <= 1'b0;
    end else if (en) begin
      mz_valid <= fd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mz_z <= bqc_pkg::xy_t'(z_prod[61:30]);
      mz_neg <= fd_neg;
      mz_pay <= fd_pay;
    end
  end

  // cordic
  logic              cr_valid [CORN+1];
  bqc_pkg::xy_t      cr_x     [CORN+1];
  bqc_pkg::xy_t      cr_y     [CORN+1];
  bqc_pkg::xy_t      cr_z     [CORN+1];
  bqc_pkg::cor_pay_t cr_pay   [CORN+1];

  assign cr_valid[0] = mz_valid;
  assign cr_x[0] = bqc_pkg::CORDIC_X0;
  assign cr_y[0] = '0;
  assign cr_z[0] = mz_z;
  assign cr_pay[0] = '{stage: mz_pay.stage, q: mz_pay.q, limited: mz_pay.limited,
                       amp: mz_pay.amp, inv: mz_pay.inv, negcos: mz_neg};

  for (genvar k = 0; k < CORN; k++) begin : g_cor
    bqc_cordic_cell #(.I(k), .PW(COR_PW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cr_valid[k]), .in_x(cr_x[k]), .in_y(cr_y[k]), .in_z(cr_z[k]),
      .in_pay(cr_pay[k]),
      .out_valid(cr_valid[k+1]), .out_x(cr_x[k+1]), .out_y(cr_y[k+1]), .out_z(cr_z[k+1]),
      .out_pay(cr_pay[k+1])
    );
  end

  // alpha divider: sin * 2048 / q
  bqc_pkg::xy_t cos_v;
  bqc_pkg::xy_t sin_v;

  assign cos_v = cr_pay[CORN].negcos ? -cr_x[CORN] : cr_x[CORN];
  assign sin_v = cr_y[CORN][bqc_pkg::XYW-1] ? '0 : cr_y[CORN];

  logic              al_valid [AL_STEPS+1];
  logic [15:0]       al_rem   [AL_STEPS+1];
  logic [15:0]       al_den   [AL_STEPS+1];
  logic [33:0]       al_num   [AL_STEPS+1];
  logic [33:0]       al_quo   [AL_STEPS+1];
  bqc_pkg::al_pay_t  al_pay   [AL_STEPS+1];

  assign al_valid[0] = cr_valid[CORN];
  assign al_rem[0] = 16'(sin_v[33:23]);
  assign al_den[0] = cr_pay[CORN].q;
  assign al_num[0] = {sin_v[22:0], 11'd0};
  assign al_quo[0] = '0;
  assign al_pay[0] = '{stage: cr_pay[CORN].stage, limited: cr_pay[CORN].limited,
                       amp: cr_pay[CORN].amp, inv: cr_pay[CORN].inv, cc: cos_v};

  for (genvar k = 0; k < AL_STEPS; k++) begin : g_al
    bqc_div_cell #(.DENW(16), .NW(AL_STEPS), .QW(AL_STEPS), .PW(AL_PW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(al_valid[k]), .in_rem(al_rem[k]), .in_den(al_den[k]),
      .in_num(al_num[k]), .in_quo(al_quo[k]), .in_pay(al_pay[k]),
      .out_valid(al_valid[k+1]), .out_rem(al_rem[k+1]), .out_den(al_den[k+1]),
      .out_num(al_num[k+1]), .out_quo(al_quo[k+1]), .out_pay(al_pay[k+1])
    );
  end

  // alpha*A and alpha/A
  logic [65:0]  prod_aa;
  logic [65:0]  prod_ai;
  logic         mp_valid;
  logic [33:0]  mp_alpha;
  logic [35:0]  mp_aa;
  logic [35:0]  mp_ai;
  bqc_pkg::xy_t mp_cc;
  logic [2:0]   mp_stage;
  logic         mp_lim;

  assign prod_aa = 66'(al_quo[AL_STEPS]) * 66'(al_pay[AL_STEPS].amp);
  assign prod_ai = 66'(al_quo[AL_STEPS]) * 66'(al_pay[AL_STEPS].inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_valid <= 1'b0;
    end else if (en) begin
      mp_valid <= al_valid[AL_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp_alpha <= al_quo[AL_STEPS];
      mp_aa <= prod_aa[65:30];
      mp_ai <= prod_ai[65:30];
      mp_cc <= al_pay[AL_STEPS].cc;
      mp_stage <= al_pay[AL_STEPS].stage;
      mp_lim <= al_pay[AL_STEPS].limited;
    end
  end

  // numerators and a0
  bqc_pkg::band_kind_t kind;
  logic signed [37:0]  cc38;
  logic signed [37:0]  v_hl;
  logic signed [37:0]  half_hl;
  logic signed [37:0]  a1_v;
  logic signed [37:0]  den_v;
  logic signed [37:0]  num_v [LANES];

  always_comb begin
    if (mp_stage == 3'd0) begin
      kind = bqc_pkg::KIND_HIGHPASS;
    end else if (mp_stage == 3'(NUM_STAGES - 1)) begin
      kind = bqc_pkg::KIND_LOWPASS;
    end else begin
      kind = bqc_pkg::KIND_PEAK;
    end
  end

  always_comb begin
    cc38 = 38'(mp_cc);
    a1_v = -(cc38 + cc38);
    v_hl = (kind == bqc_pkg::KIND_HIGHPASS) ? bqc_pkg::ONE_Q30 + cc38
                                            : bqc_pkg::ONE_Q30 - cc38;
    // halve toward zero
    half_hl = (v_hl + $signed({37'd0, v_hl[37]})) >>> 1;
    case (kind)
      bqc_pkg::KIND_HIGHPASS, bqc_pkg::KIND_LOWPASS: begin
        den_v = bqc_pkg::ONE_Q30 + 38'(mp_alpha);
        num_v[0] = half_hl;
        num_v[1] = (kind == bqc_pkg::KIND_HIGHPASS) ? -v_hl : v_hl;
        num_v[2] = half_hl;
        num_v[4] = bqc_pkg::ONE_Q30 - 38'(mp_alpha);
      end
      default: begin
        den_v = bqc_pkg::ONE_Q30 + 38'(mp_ai);
        num_v[0] = bqc_pkg::ONE_Q30 + 38'(mp_aa);
        num_v[1] = a1_v;
        num_v[2] = bqc_pkg::ONE_Q30 - 38'(mp_aa);
        num_v[4] = bqc_pkg::ONE_Q30 - 38'(mp_ai);
      end
    endcase
    num_v[3] = a1_v;
  end

  logic               nm_valid;
  logic signed [37:0] nm_num [LANES];
  logic [QD_DENW-1:0] nm_den;
  logic [2:0]         nm_stage;
  logic               nm_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (en) begin
      nm_valid <= mp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_num <= num_v;
      nm_den <= den_v[QD_DENW-1:0];
      nm_stage <= mp_stage;
      nm_lim <= mp_lim;
    end
  end

  // divider setup: rounding offset and overflow check
  logic [36:0]        mag_v  [LANES];
  logic [65:0]        dvd_v  [LANES];
  logic [LANES-1:0]   ovf_v;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_v[l] = nm_num[l][37] ? 37'(-nm_num[l]) : nm_num[l][36:0];
      dvd_v[l] = {1'b0, mag_v[l], 28'd0} + 66'(nm_den >> 1);
      ovf_v[l] = {3'b000, dvd_v[l][65:32]} >= nm_den;
    end
  end

  logic               qp_valid;
  logic [QD_DENW-1:0] qp_rem [LANES];
  logic [31:0]        qp_num [LANES];
  logic [LANES-1:0]   qp_neg;
  logic [LANES-1:0]   qp_ovf;
  logic [QD_DENW-1:0] qp_den;
  logic [2:0]         qp_stage;
  logic               qp_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      qp_valid <= 1'b0;
    end else if (en) begin
      qp_valid <= nm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        qp_rem[l] <= QD_DENW'(dvd_v[l][65:32]);
        qp_num[l] <= dvd_v[l][31:0];
        qp_neg[l] <= nm_num[l][37];
      end
      qp_ovf <= ovf_v;
      qp_den <= nm_den;
      qp_stage <= nm_stage;
      qp_lim <= nm_lim;
    end
  end

  // five coefficient dividers sharing a0
  logic               qd_valid [LANES][QD_STEPS+1];
  logic [QD_DENW-1:0] qd_rem   [LANES][QD_STEPS+1];
  logic [QD_DENW-1:0] qd_den   [LANES][QD_STEPS+1];
  logic [31:0]        qd_num   [LANES][QD_STEPS+1];
  logic [31:0]        qd_quo   [LANES][QD_STEPS+1];
  bqc_pkg::qd_pay_t   qd_pay   [LANES][QD_STEPS+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign qd_valid[l][0] = qp_valid;
    assign qd_rem[l][0] = qp_rem[l];
    assign qd_den[l][0] = qp_den;
    assign qd_num[l][0] = qp_num[l];
    assign qd_quo[l][0] = '0;
    assign qd_pay[l][0] = '{stage: qp_stage, limited: qp_lim, neg: qp_neg[l],
                            ovf: qp_ovf[l]};
    for (genvar k = 0; k < QD_STEPS; k++) begin : g_step
      bqc_div_cell #(.DENW(QD_DENW), .NW(QD_STEPS), .QW(QD_STEPS), .PW(QD_PW)) u_cell (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(qd_valid[l][k]), .in_rem(qd_rem[l][k]), .in_den(qd_den[l][k]),
        .in_num(qd_num[l][k]), .in_quo(qd_quo[l][k]), .in_pay(qd_pay[l][k]),
        .out_valid(qd_valid[l][k+1]), .out_rem(qd_rem[l][k+1]), .out_den(qd_den[l][k+1]),
        .out_num(qd_num[l][k+1]), .out_quo(qd_quo[l][k+1]), .out_pay(qd_pay[l][k+1])
      );
    end
  end

  // saturate and pack
  logic             last_valid;
  logic [31:0]      quo_l;
  logic [159:0]     data_next;

  always_comb begin
    last_valid = 1'b1;
    data_next = '0;
    for (int l = 0; l < LANES; l++) begin
      last_valid = last_valid & qd_valid[l][QD_STEPS];
      quo_l = qd_quo[l][QD_STEPS];
      if (qd_pay[l][QD_STEPS].neg) begin
        if (qd_pay[l][QD_STEPS].ovf || quo_l > bqc_pkg::COEF_NEG_MAX) begin
          data_next[32*l +: 32] = bqc_pkg::COEF_NEG_MAX;
        end else begin
          data_next[32*l +: 32] = -quo_l;
        end
      end else begin
        if (qd_pay[l][QD_STEPS].ovf || quo_l > bqc_pkg::COEF_POS_MAX) begin
          data_next[32*l +: 32] = bqc_pkg::COEF_POS_MAX;
        end else begin
          data_next[32*l +: 32] = quo_l;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= data_next;
      m_tuser <= {qd_pay[0][QD_STEPS].limited, qd_pay[0][QD_STEPS].stage};
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output beat right after reset");

  a_pass_symmetric: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == 3'd0 || m_tuser[2:0] == 3'(NUM_STAGES - 1))
    |-> m_tdata[31:0] == m_tdata[95:64])
    else $error("high/low pass b0 and b2 differ");

  a_peak_b1_a1: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] != 3'd0 && m_tuser[2:0] != 3'(NUM_STAGES - 1)
    |-> m_tdata[63:32] == m_tdata[127:96])
    else $error("peaking b1 and a1 differ");

endmodule

// ----- verif/bqc_checker.sv -----
`timescale 1ns / 100ps

module bqc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic [3:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending,
  output int           coefs_seen
);

  localparam int NUM_BANDS = 5;

  typedef struct {
    logic [2:0]  stage;
    logic [31:0] c[5];
    logic        limited;
  } coef_set_t;

  coef_set_t coef_q[$];
  logic [17:0] rate;

  const longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
  const longint root_tab[20] = '{1518500250, 1276901417, 1170923762, 1121280436,
    1097253708, 1085434106, 1079572136, 1076653034, 1075196444, 1074468888,
    1074105294, 1073923544, 1073832680, 1073787251, 1073764537, 1073753181,
    1073747502, 1073744663, 1073743244, 1073742534};

  function automatic longint pow2_q30(longint e);
    longint n, frac, r;
    n = e >>> 30;
    frac = e - n * 64'sd1073741824;
    r = 64'sd1073741824;
    for (int k = 1; k <= 20; k++)
      if ((frac >> (30 - k)) & 1) r = (r * root_tab[k-1]) >>> 30;
    if (n >= 0) return r << (n & 3);
    return r >>> ((-n) & 3);
  endfunction

  function automatic logic [31:0] div_q28(longint num, longint den);
    bit neg;
    longint unsigned mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 28) + den / 2) / den;
    if (neg) return q > 64'd2147483648 ? 32'h80000000 : 32'(-longint'(q));
    return q > 64'd2147483647 ? 32'h7fffffff : 32'(q);
  endfunction

  function automatic coef_set_t band_coefs(logic [2:0] stage, logic [18:0] f16,
                                           logic [15:0] qin, logic signed [13:0] gin);
    coef_set_t r;
    longint g, q, t, x, y, z, dx, dy, cc, s, alpha, aa, ai, amp, inv;
    longint a0, a1, a2, b0, b1, b2;
    bit negcos;
    g = gin;
    q = qin;
    negcos = 0;
    x = 652032874;
    y = 0;
    if (g < -4608) g = -4608;
    if (g > 4608) g = 4608;
    if (q < 410) q = 410;
    if (q > 40960) q = 40960;
    r.limited = 0;
    if (longint'(f16) >= 8 * longint'(rate)) begin
      t = 64'd2147483647;
      r.limited = 1;
    end else begin
      t = (longint'(f16) << 28) / rate;
    end
    if (t > 64'sd1073741824) begin
      t = 64'sd2147483648 - t;
      negcos = 1;
    end
    z = (t * 64'sd1686629713) >>> 30;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    cc = negcos ? -x : x;
    s = y < 0 ? 0 : y;
    alpha = (s * 2048) / q;
    a1 = -2 * cc;
    if (stage == 0) begin
      a0 = 64'sd1073741824 + alpha;
      a2 = 64'sd1073741824 - alpha;
      b1 = -(64'sd1073741824 + cc);
      b0 = (64'sd1073741824 + cc) / 2;
      b2 = b0;
    end else if (stage == NUM_BANDS - 1) begin
      a0 = 64'sd1073741824 + alpha;
      a2 = 64'sd1073741824 - alpha;
      b1 = 64'sd1073741824 - cc;
      b0 = (64'sd1073741824 - cc) / 2;
      b2 = b0;
    end else begin
      amp = pow2_q30(g * 348329);
      inv = pow2_q30(-g * 348329);
      // products can pass 2^63
      aa = ($unsigned(alpha) * $unsigned(amp)) >> 30;
      ai = ($unsigned(alpha) * $unsigned(inv)) >> 30;
      a0 = 64'sd1073741824 + ai;
      a2 = 64'sd1073741824 - ai;
      b0 = 64'sd1073741824 + aa;
      b1 = a1;
      b2 = 64'sd1073741824 - aa;
    end
    r.stage = stage;
    r.c[0] = div_q28(b0, a0);
    r.c[1] = div_q28(b1, a0);
    r.c[2] = div_q28(b2, a0);
    r.c[3] = div_q28(a1, a0);
    r.c[4] = div_q28(a2, a0);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    coef_set_t w;
    if (rst) begin
      rate <= bqc_pkg::SAMPLE_RATE_RESET;
      errors <= 0;
      coefs_seen <= 0;
      pending <= 0;
      coef_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:2] == bqc_pkg::REG_SAMPLE_RATE)
        rate <= pwdata[17:0];
      if (s_tvalid && s_tready)
        coef_q.push_back(band_coefs(s_tuser, s_tdata[18:0], s_tdata[34:19], s_tdata[48:35]));
      if (m_tvalid && m_tready) begin
        coefs_seen <= coefs_seen + 1;
        if (coef_q.size() == 0) begin
          report("unexpected beat", m_tdata[31:0], 32'd0);
        end else begin
          w = coef_q.pop_front();
          if (m_tuser[2:0] != w.stage) report("stage", m_tuser[2:0], w.stage);
          if (m_tuser[3] != w.limited) report("freq_limited", m_tuser[3], w.limited);
          for (int i = 0; i < 5; i++)
            if (m_tdata[32*i +: 32] != w.c[i]) report($sformatf("coef %0d", i),
                                                      m_tdata[32*i +: 32], w.c[i]);
        end
      end
      pending <= coef_q.size();
    end
  end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [55:0] s_tdata;
  logic [2:0] s_tuser;
  logic [159:0] m_tdata;
  logic [3:0] m_tuser;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  int errors, pending, coefs_seen;
  int idle_cycles;
  bit hold_off;
  int sent;

  biquad_eq_coefficient_calc_unit uut (.*);
  bqc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_rate(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_band(logic [2:0] st, logic [18:0] f, logic [15:0] q,
                           logic [13:0] g);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= st;
    s_tdata <= {7'd0, g, q, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(int n, logic [17:0] sr);
    logic [18:0] f;
    logic [15:0] q;
    logic [13:0] g;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: f = 19'($urandom);
        1: f = 19'(8 * sr + $urandom_range(0, 16));
        default: f = 19'($urandom_range(320, 320000));
      endcase
      q = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(410, 40960));
      g = $urandom_range(0, 7) == 0 ? 14'($urandom) : 14'($urandom_range(0, 9216) - 4608);
      send_band($urandom_range(0, 6) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4)), f, q, g);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  initial begin
    logic [17:0] rates[6];
    rates = '{18'd8000, 18'd192000, 18'd44100, 18'd0, 18'h3ffff, 18'd96000};
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_band(3'd0, 19'd320, 16'd410, 14'd0);
    send_band(3'd4, 19'd320000, 16'd40960, 14'd0);
    send_band(3'd1, 19'h7ffff, 16'hffff, 14'h1fff);
    send_band(3'd2, 19'd0, 16'd0, 14'h2000);
    send_band(3'd3, 19'd6000, 16'd4096, 14'sd4608);
    send_band(3'd1, 19'd6000, 16'd4096, -14'sd4608);
    send_band(3'd7, 19'd16000, 16'd2896, 14'sd1000);
    send_band(3'd5, 19'd384000, 16'd2896, 14'sd1000);
    send_band(3'd0, 19'd384000, 16'd2896, 14'd0);
    send_band(3'd4, 19'd383999, 16'd2896, 14'd0);
    send_band(3'd2, 19'd192000, 16'd12000, -14'sd2000);
    send_band(3'd6, 19'd100000, 16'd0, 14'h1fff);
    drain();
    foreach (rates[r]) begin
      write_rate({14'h3fff, rates[r]});
      send_random(135, rates[r]);
      drain();
    end
    write_rate(32'd48000);
    send_random(30, 18'd48000);
    drain();
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else m_tready <= gap_len() == 0;
    end
  end

  initial begin
    hold_off = 0;
    wait (sent == 300);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (sent >= 852 && pending == 0 && idle_cycles > 200) begin
        $display("covered %0d band requests and %0d coefficient beats over six sample rates",
                 sent, coefs_seen);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
      end
      if (idle_cycles > 5000) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end
endmodule
